// ===== rtl/cpgi_pkg.sv =====
// shared types and constants of the codepoint range glyph index block
`timescale 1ns / 1ps

package cpgi_pkg;

    localparam int FIELD_W = 21;
    localparam int CFG_W   = 5;
    localparam int IDX_W   = 4;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [FIELD_W-1:0] SAT_MAX = {FIELD_W{1'b1}};

    // one range entry written into a cell
    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
    } t_entry;

    // lookup token that walks down the chain of cells
    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] cp;
        logic [FIELD_W-1:0] acc;
        logic               found;
        logic [CFG_W-1:0]   remaining;
    } t_probe;

    // saturate a grown sum back to the field width
    function automatic logic [FIELD_W-1:0] sat_field(input logic [FIELD_W:0] sum);
        sat_field = sum[FIELD_W] ? SAT_MAX : sum[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/cpgi_cell.sv =====
// one range cell: holds a table entry and tests the passing lookup token
`timescale 1ns / 1ps

module cpgi_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_wr_en,
    input  cpgi_pkg::t_entry i_wr,
    input  cpgi_pkg::t_probe i_probe,
    output cpgi_pkg::t_probe o_probe
);

    logic [cpgi_pkg::FIELD_W-1:0] r_start;
    logic [cpgi_pkg::FIELD_W-1:0] r_len;
    logic [cpgi_pkg::FIELD_W:0]   r_end;
    cpgi_pkg::t_probe             r_probe;
    cpgi_pkg::t_probe             n_probe;

    logic                         hit;
    logic                         active;
    logic [cpgi_pkg::FIELD_W:0]   sum_hit;
    logic [cpgi_pkg::FIELD_W:0]   sum_miss;

    // entry storage, end kept one bit wider so a range never wraps
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_start <= i_wr.start;
            r_len   <= i_wr.length;
            r_end   <= {1'b0, i_wr.start} + {1'b0, i_wr.length};
        end
    end

    always_comb begin
        active   = i_probe.valid && !i_probe.found && (i_probe.remaining != '0);
        hit      = (i_probe.cp >= r_start) && ({1'b0, i_probe.cp} < r_end);
        sum_hit  = {1'b0, i_probe.acc} + {1'b0, i_probe.cp} - {1'b0, r_start};
        sum_miss = {1'b0, i_probe.acc} + {1'b0, r_len};
        n_probe  = i_probe;
        if (active) begin
            n_probe.remaining = i_probe.remaining - 1'b1;
            if (hit) begin
                n_probe.found = 1'b1;
                n_probe.acc   = cpgi_pkg::sat_field(sum_hit);
            end else begin
                n_probe.acc   = cpgi_pkg::sat_field(sum_miss);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else if (i_adv) begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

// ===== rtl/codepoint_range_glyph_index.sv =====
// top level: load and lookup control, chain of range cells, result register
`timescale 1ns / 1ps

// Codepoint to dense glyph index mapper. Each range of the table lives in one cell of a
// chain of MAX_RANGES cells. A load transaction writes one cell and gives no result. A
// lookup transaction sends a token down the chain, one cell per cycle; the token waits at
// the end of the chain while the full result register is stalled, then moves into it. One
// lookup is in the chain at a time, and a new transaction is taken once the previous lookup
// has left the chain, even while its result still waits in the output register. The user
// must write blocks_in_use through the config port only while the block is idle; the block
// itself does not enforce this.

module codepoint_range_glyph_index #(
    parameter int MAX_RANGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [cpgi_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [cpgi_pkg::FIELD_W-1:0]  i_range_start,
    input  logic [cpgi_pkg::FIELD_W-1:0]  i_range_length,
    input  logic [cpgi_pkg::FIELD_W-1:0]  i_codepoint,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cpgi_pkg::FIELD_W-1:0]  o_glyph_index,
    output logic                          o_in_range,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cpgi_pkg::CFG_W-1:0]    i_cfg_blocks_in_use
);

    localparam int CFG_MAX  = (1 << cpgi_pkg::CFG_W) - 1;
    localparam int USED_CAP = (MAX_RANGES < CFG_MAX) ? MAX_RANGES : CFG_MAX;

    logic [cpgi_pkg::CFG_W-1:0]   r_blocks;
    logic                         r_busy;
    logic                         r_out_valid;
    logic [cpgi_pkg::FIELD_W-1:0] r_glyph;
    logic                         r_in_range;

    logic                         in_accept;
    logic                         load_acc;
    logic                         lookup_acc;
    logic                         out_take;
    logic                         adv;
    logic [cpgi_pkg::CFG_W-1:0]   used;
    logic [cpgi_pkg::CFG_W-1:0]   searched;
    cpgi_pkg::t_entry             wr_entry;
    cpgi_pkg::t_probe             chain [MAX_RANGES+1];
    cpgi_pkg::t_probe             tail;
    logic [MAX_RANGES-1:0]        wr_en;
    logic [MAX_RANGES-1:0]        cell_valid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy;
    assign in_accept   = i_in_valid && !r_busy;
    assign load_acc    = in_accept && (i_func == cpgi_pkg::FUNC_LOAD);
    assign lookup_acc  = in_accept && (i_func == cpgi_pkg::FUNC_LOOKUP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks <= cpgi_pkg::CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_blocks <= i_cfg_blocks_in_use;
        end
    end

    // number of ranges searched: in-use count capped at the table size, minus the last one
    always_comb begin
        if (32'(r_blocks) > USED_CAP) begin
            used = cpgi_pkg::CFG_W'(USED_CAP);
        end else begin
            used = r_blocks;
        end
        searched = (used == '0) ? '0 : used - 1'b1;
    end

    always_comb begin
        wr_entry.start  = i_range_start;
        wr_entry.length = i_range_length;
        chain[0].valid     = lookup_acc;
        chain[0].cp        = i_codepoint;
        chain[0].acc       = '0;
        chain[0].found     = 1'b0;
        chain[0].remaining = searched;
    end

    assign tail     = chain[MAX_RANGES];
    assign out_take = !r_out_valid || !i_out_stall;
    assign adv      = out_take || !tail.valid;

    for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
        // loads beyond the table match no cell and are dropped
        assign wr_en[k]      = load_acc && (32'(i_entry_index) == k);
        assign cell_valid[k] = chain[k+1].valid;

        cpgi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_wr_en (wr_en[k]),
            .i_wr    (wr_entry),
            .i_probe (chain[k]),
            .o_probe (chain[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (lookup_acc) begin
                r_busy <= 1'b1;
            end else if (tail.valid && out_take) begin
                r_busy <= 1'b0;
            end
            if (out_take) begin
                r_out_valid <= tail.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.valid && out_take) begin
            r_glyph    <= tail.acc;
            r_in_range <= tail.found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_glyph_index = r_glyph;
    assign o_in_range    = r_in_range;

    // at most one lookup token in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_valid) <= 1)
        else $error("more than one lookup in the cell chain");

    // chain is empty whenever the block takes new transactions
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (cell_valid == '0))
        else $error("token in chain while not busy");

    // an accepted lookup keeps the block busy next cycle
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lookup_acc |=> r_busy && !o_out_valid || r_busy)
        else $error("lookup accepted but block not busy");

    // a token leaving the chain frees the input and shows up as a result
    a_tail_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail.valid && out_take) |=> !r_busy && o_out_valid)
        else $error("lookup result lost at chain exit");

endmodule
